[hdl/substring_first_match_search_macros.svh]
// assertion macros for the substring search block
// used by the top level only; expects clk and rst_n in scope
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_MACROS_SVH

// checked only while out of reset
`define SFMS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SFMS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sfms_pkg.sv]
// shared types and constants for the substring search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfms_pkg;

  localparam int PATTERN_MAX_DEF   = 8;
  localparam int POSITION_BITS_DEF = 16;

  localparam int BYTE_W      = 8;
  localparam int PAT_BYTES_W = 64;
  localparam int PAT_LEN_W   = 4;
  localparam int INDEX_W     = 16;

  // configuration register indexes
  typedef enum logic {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_e;

  // control shared by every window cell
  typedef struct packed {
    logic                 shift;
    logic                 clear;
    logic [PAT_LEN_W-1:0] len;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/sfms_cell.sv]
// one window cell: holds one recent text byte and compares the byte at its input with its pattern byte
// depends on sfms_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfms_cell #(
  parameter int CELL_IDX    = 0,
  parameter int PATTERN_MAX = sfms_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire sfms_pkg::cell_ctrl_t                      ctrl,
  input  wire logic [PATTERN_MAX*sfms_pkg::BYTE_W-1:0]   pattern,
  input  wire logic [sfms_pkg::BYTE_W-1:0]               byte_in,
  output logic      [sfms_pkg::BYTE_W-1:0]               byte_out,
  output logic                                           hit
);
  import sfms_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;
  logic [BYTE_W-1:0] want;
  logic              active;

  // the byte this cell must hold is pattern[len-1-CELL_IDX]
  always_comb begin
    want = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (k + CELL_IDX + 1 == int'(ctrl.len)) begin
        want = pattern[k*BYTE_W +: BYTE_W];
      end
    end
    active = int'(ctrl.len) > CELL_IDX;
    // compare against the byte arriving this cycle
    hit = !active || (byte_in == want);
  end

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.shift) begin
      byte_nxt = ctrl.clear ? '0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

[hdl/substring_first_match_search.sv]
// top level of the substring search block: config registers, window cell row,
// position tracking and the result register; depends on sfms_pkg, sfms_cell
// and substring_first_match_search_macros.svh
// usage
//   - write the pattern (byte 0 in the low bits) to register 0 and its length to
//     register 1 through cfg_wr_en / cfg_index / cfg_wr_data, only while idle
//   - stream text one byte per item on in_*, in_last_byte marks the final byte
//   - one result item per text, on out_*: found flag, start of the leftmost
//     match (zero when not found) and a flag for a text that ran past the
//     position counter
// timing
//   - one text byte accepted per cycle while in_stall is low; every byte does its full
//     compare in the cycle it is accepted, across the row of window cells
//   - the result is registered and appears in the cycle after the last byte is accepted
//   - in_stall is high only while a result waits and out_stall holds it, so a
//     result taken in the same cycle does not cost an input slot
// reset
//   - synchronous, active low; clears pattern, length, window, counters and the
//     result valid flag, the next text starts at position zero
//   - after each final byte the text state clears for the next text
`timescale 1ns / 1ps
`default_nettype none
`include "substring_first_match_search_macros.svh"

module substring_first_match_search #(
  parameter int PATTERN_MAX   = sfms_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_BITS = sfms_pkg::POSITION_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_index,
  input  wire logic [sfms_pkg::PAT_BYTES_W-1:0]   cfg_wr_data,
  // text items
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [sfms_pkg::BYTE_W-1:0]        in_text_byte,
  input  wire logic                               in_last_byte,
  // result items
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_found,
  output logic      [sfms_pkg::INDEX_W-1:0]       out_match_index,
  output logic                                    out_length_overflow
);
  import sfms_pkg::*;

  // configuration registers
  logic [PAT_BYTES_W-1:0] pat_bytes_r, pat_bytes_nxt;
  logic [PAT_LEN_W-1:0]   pat_len_r, pat_len_nxt;

  // text state
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     match_seen_r, match_seen_nxt;
  logic [POSITION_BITS-1:0] first_pos_r, first_pos_nxt;
  logic                     over_r, over_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic               out_over_r, out_over_nxt;

  logic                     in_acc;
  logic                     out_acc;
  cell_ctrl_t               ctrl;
  logic [BYTE_W-1:0]        link [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0]   hits;
  logic                     len_ok;
  logic                     pos_ok;
  logic                     match_now;
  logic [POSITION_BITS:0]   pos_plus;
  logic [POSITION_BITS:0]   start_ext;
  logic                     found_fin;
  logic [POSITION_BITS-1:0] first_fin;
  logic [POSITION_BITS+INDEX_W-1:0] first_wide;

  // overflow for the final byte includes the byte that hits the counter limit
  function automatic logic over_nxt_flag(input logic over_q,
                                         input logic [POSITION_BITS-1:0] pos_q);
    over_nxt_flag = over_q || (&pos_q);
  endfunction

  // handshakes; a waiting result only blocks input while it is stalled
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // configuration writes
  always_comb begin
    pat_bytes_nxt = pat_bytes_r;
    pat_len_nxt   = pat_len_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pat_bytes_nxt = cfg_wr_data;
        REG_PATTERN_LENGTH: pat_len_nxt   = cfg_wr_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // window: cell j compares the byte that arrived j items ago and holds it for cell j+1
  assign ctrl.shift = in_acc;
  assign ctrl.clear = in_acc && in_last_byte;
  assign ctrl.len   = pat_len_r;
  assign link[0]    = in_text_byte;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    sfms_cell #(
      .CELL_IDX    (j),
      .PATTERN_MAX (PATTERN_MAX)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pattern  (pat_bytes_r[PATTERN_MAX*BYTE_W-1:0]),
      .byte_in  (link[j]),
      .byte_out (link[j+1]),
      .hit      (hits[j])
    );
  end

  // a match ending at this byte needs a usable length and enough bytes seen
  always_comb begin
    pos_plus  = {1'b0, pos_r} + {{POSITION_BITS{1'b0}}, 1'b1};
    start_ext = pos_plus - {{(POSITION_BITS+1-PAT_LEN_W){1'b0}}, pat_len_r};
    len_ok    = (pat_len_r != '0) && (int'(pat_len_r) <= PATTERN_MAX);
    pos_ok    = pos_plus >= {{(POSITION_BITS+1-PAT_LEN_W){1'b0}}, pat_len_r};
    match_now = !over_r && !match_seen_r && len_ok && pos_ok && (&hits);
  end

  // text state update; the counter saturates and then flags overflow
  always_comb begin
    pos_nxt        = pos_r;
    match_seen_nxt = match_seen_r;
    first_pos_nxt  = first_pos_r;
    over_nxt       = over_r;
    found_fin      = match_seen_r || match_now;
    first_fin      = match_seen_r ? first_pos_r
                   : (match_now ? start_ext[POSITION_BITS-1:0] : '0);
    if (in_acc) begin
      if (match_now) begin
        match_seen_nxt = 1'b1;
        first_pos_nxt  = start_ext[POSITION_BITS-1:0];
      end
      if (!over_r) begin
        if (!(&pos_r)) begin
          pos_nxt = pos_plus[POSITION_BITS-1:0];
        end else begin
          over_nxt = 1'b1;
        end
      end
      // final byte: start the next text from scratch
      if (in_last_byte) begin
        pos_nxt        = '0;
        match_seen_nxt = 1'b0;
        first_pos_nxt  = '0;
        over_nxt       = 1'b0;
      end
    end
  end

  // the index port carries the low bits of the position
  assign first_wide = {{INDEX_W{1'b0}}, first_fin};

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    out_over_nxt  = out_over_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_fin;
      out_index_nxt = found_fin ? first_wide[INDEX_W-1:0] : '0;
      out_over_nxt  = over_nxt_flag(over_r, pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r  <= '0;
      pat_len_r    <= '0;
      pos_r        <= '0;
      match_seen_r <= 1'b0;
      first_pos_r  <= '0;
      over_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pat_bytes_r  <= pat_bytes_nxt;
      pat_len_r    <= pat_len_nxt;
      pos_r        <= pos_nxt;
      match_seen_r <= match_seen_nxt;
      first_pos_r  <= first_pos_nxt;
      over_r       <= over_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
    out_over_r  <= out_over_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_match_index     = out_index_r;
  assign out_length_overflow = out_over_r;

  // checks
  `SFMS_ASSERT_ANY(a_reset_no_result, !rst_n |=> !out_valid_r, "result valid after reset")
  `SFMS_ASSERT_CLK(a_result_from_last, $rose(out_valid_r) |-> $past(in_acc && in_last_byte), "result without final byte")
  `SFMS_ASSERT_CLK(a_index_zero_not_found, out_valid_r && !out_found_r |-> out_index_r == '0, "index set without a match")
  `SFMS_ASSERT_CLK(a_overflow_saturated, over_r |-> (&pos_r), "overflow before counter saturated")

endmodule

`default_nettype wire

[tb/substring_first_match_search_tb.sv]
// self-checking testbench for substring_first_match_search
// depends on sfms_pkg and the block itself; predicts results with its own search tracker
`timescale 1ns / 1ps

module substring_first_match_search_tb;
  import sfms_pkg::*;

  localparam int WIN_DEPTH   = PATTERN_MAX_DEF;
  localparam int POS_LAST    = (1 << POSITION_BITS_DEF) - 1;
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 780;

  typedef struct packed {
    logic                 found;
    logic [INDEX_W-1:0]   match_index;
    logic                 length_overflow;
  } search_outcome_t;

  // tracks the text stream like the block does and queues one outcome per text
  class first_match_tracker;
    logic [PAT_BYTES_W-1:0] pattern;
    logic [PAT_LEN_W-1:0]   plen;
    logic [BYTE_W-1:0]      window [WIN_DEPTH];
    int unsigned            next_pos;
    bit                     matched;
    logic [INDEX_W-1:0]     match_pos;
    bit                     overflowed;
    search_outcome_t        outcome_q [$];
    int                     errors;

    function new();
      pattern = '0;
      plen = '0;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[k]) window[k] = '0;
      next_pos = 0;
      matched = 0;
      match_pos = '0;
      overflowed = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [PAT_BYTES_W-1:0] data);
      case (idx)
        REG_PATTERN_BYTES:  pattern = data;
        REG_PATTERN_LENGTH: plen = data[PAT_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // newest byte sits at window[0], so pattern byte 0 lines up with the oldest
    function bit window_hit(int unsigned len);
      for (int unsigned k = 0; k < len; k++) begin
        if (window[len-1-k] != pattern[8*k +: 8]) return 0;
      end
      return 1;
    endfunction

    function void take_text_byte(logic [BYTE_W-1:0] b, bit last);
      int unsigned     pos;
      int unsigned     len;
      bit              was_over;
      search_outcome_t r;
      pos = next_pos;
      len = plen;
      was_over = overflowed;
      for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (!was_over && !matched && len >= 1 && len <= WIN_DEPTH && pos + 1 >= len &&
          window_hit(len)) begin
        matched = 1;
        match_pos = INDEX_W'(pos + 1 - len);
      end
      // counter saturates; the byte landing on the top position flags overflow
      if (!was_over) begin
        if (pos < POS_LAST) next_pos = pos + 1;
        else overflowed = 1;
      end
      if (last) begin
        r.found = matched;
        r.match_index = matched ? match_pos : '0;
        r.length_overflow = overflowed;
        outcome_q.push_back(r);
        clear_text();
      end
    endfunction

    function void check_outcome(logic found, logic [INDEX_W-1:0] idx, logic ovf);
      search_outcome_t e;
      if (outcome_q.size() == 0) begin
        $error("result item with no text pending: found %0d index %0d overflow %0d",
               found, idx, ovf);
        errors++;
        return;
      end
      e = outcome_q.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (idx !== e.match_index) begin
        $error("match_index: expected %0d, got %0d", e.match_index, idx);
        errors++;
      end
      if (ovf !== e.length_overflow) begin
        $error("length_overflow: expected %0d, got %0d", e.length_overflow, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  cfg_reg_e               cfg_index;
  logic [PAT_BYTES_W-1:0] cfg_wr_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_text_byte;
  logic                   in_last_byte;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_found;
  logic [INDEX_W-1:0]     out_match_index;
  logic                   out_length_overflow;

  first_match_tracker     tracker;
  bit                     no_idle = 1'b0;
  int                     quiet_cycles = 0;
  logic [BYTE_W-1:0]      sym [4];
  logic [BYTE_W-1:0]      text_q [$];
  int                     random_items = 0;

  always #2 clk = ~clk;

  substring_first_match_search dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_text_byte        (in_text_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_match_index     (out_match_index),
    .out_length_overflow (out_length_overflow)
  );

  // result side: random stalls, checking, and a watchdog on accepted items
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall)
        tracker.check_outcome(out_found, out_match_index, out_length_overflow);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
      out_stall <= !no_idle && ($urandom_range(99) < 16);
    end
  end

  // one text byte; returns right after the edge that accepted it
  task automatic send_byte(logic [BYTE_W-1:0] b, bit last);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    tracker.take_text_byte(b, last);
  endtask

  task automatic send_str(string s, bit close_text);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], close_text && (k == s.len() - 1));
  endtask

  task automatic send_queued_text(bit close_text);
    foreach (text_q[k]) send_byte(text_q[k], close_text && (k == text_q.size() - 1));
  endtask

  // filler below 0x80 never hits a pattern made of bytes 0x80 and up
  task automatic send_long_text(int n, int plant_at);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      if (i >= plant_at && i < plant_at + tracker.plen)
        b = tracker.pattern[8*(i-plant_at) +: 8];
      else
        b = BYTE_W'($urandom_range(127));
      send_byte(b, i == n - 1);
    end
  endtask

  // sender holds off until every outcome is in, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // upper bits of the length write are junk on purpose, only the low nibble counts
  task automatic program_pattern(logic [PAT_BYTES_W-1:0] bytes_val, logic [PAT_LEN_W-1:0] len);
    logic [PAT_BYTES_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[PAT_LEN_W-1:0] = len;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PATTERN_BYTES;
    cfg_wr_data <= bytes_val;
    @(posedge clk);
    tracker.write_reg(REG_PATTERN_BYTES, bytes_val);
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_wr_data <= len_word;
    @(posedge clk);
    tracker.write_reg(REG_PATTERN_LENGTH, len_word);
    cfg_wr_en <= 1'b0;
  endtask

  // random pattern drawn mostly from a small symbol pool so texts hit it often
  task automatic program_random_pattern();
    logic [PAT_BYTES_W-1:0] pat;
    logic [PAT_LEN_W-1:0]   len;
    int                     pick;
    foreach (sym[k]) sym[k] = BYTE_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 6) len = '0;
    else if (pick < 14) len = PAT_LEN_W'($urandom_range(15, WIN_DEPTH + 1));
    else len = PAT_LEN_W'($urandom_range(WIN_DEPTH, 1));
    if ($urandom_range(9) == 0) begin
      pat = {$urandom, $urandom};
    end else begin
      for (int k = 0; k < WIN_DEPTH; k++) pat[8*k +: 8] = sym[$urandom_range(3)];
    end
    program_pattern(pat, len);
  endtask

  task automatic build_random_text();
    int n;
    int at;
    bit wide;
    n = ($urandom_range(9) == 0) ? $urandom_range(120, 25) : $urandom_range(24, 1);
    wide = $urandom_range(99) < 15;
    text_q.delete();
    for (int i = 0; i < n; i++)
      text_q.push_back(wide ? BYTE_W'($urandom_range(255)) : sym[$urandom_range(3)]);
    if ($urandom_range(99) < 35 && tracker.plen >= 1 && tracker.plen <= WIN_DEPTH &&
        tracker.plen <= n) begin
      at = $urandom_range(n - tracker.plen);
      for (int k = 0; k < tracker.plen; k++) text_q[at+k] = tracker.pattern[8*k +: 8];
    end
  endtask

  initial begin
    int texts;
    tracker = new();
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_PATTERN_BYTES;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_text_byte <= '0;
    in_last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern straight out of reset, zero bytes would otherwise line up
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // "ab": match in the middle, leftmost of two, and a text shorter than the pattern
    program_pattern(64'h6261, 4'd2);
    send_str("xab", 1'b1);
    send_str("abab", 1'b1);
    send_str("a", 1'b1);
    drain();

    // all-ones pattern at full length, then an oversized length
    program_pattern('1, 4'd8);
    for (int k = 0; k < WIN_DEPTH; k++) send_byte(8'hff, k == WIN_DEPTH - 1);
    drain();
    program_pattern('1, 4'd9);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    drain();

    // pattern swapped mid-text: new pattern judged against bytes already held
    program_pattern(64'h6261, 4'd2);
    send_str("xc", 1'b0);
    drain();
    program_pattern(64'h6563, 4'd2);
    send_str("e", 1'b1);
    drain();

    // longer texts run flat out with no idling on either side
    no_idle = 1'b1;
    program_pattern(64'h838281, 4'd3);
    send_long_text(64, 30);  // match in the middle
    send_long_text(48, 45);  // match ends on the final byte
    send_long_text(40, 0);   // match at the very start
    drain();
    no_idle = 1'b0;

    // random phases; now and then a phase stops mid-text before the next pattern
    while (random_items < RANDOM_ITEMS) begin
      program_random_pattern();
      texts = $urandom_range(5, 1);
      for (int t = 0; t < texts; t++) begin
        build_random_text();
        send_queued_text(!(t == texts - 1 && $urandom_range(9) == 0));
        random_items += text_q.size();
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
